// File: sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and codes shared by the binary min-heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [19:0] node_index;
    logic [31:0] key;
  } req_item_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] out_node_index;
    logic [31:0] out_key;
    logic [10:0] entry_count;
    logic        is_empty;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_POP_LOAD,
    S_DN_CMP,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_START,
    DP_POP_START,
    DP_REFUSE_FULL,
    DP_REFUSE_EMPTY,
    DP_UP_STEP,
    DP_POP_LOAD,
    DP_DN_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic req_pop;
    logic cnt_zero;
    logic cnt_full;
    logic pos_root;
    logic up_move;
    logic dn_move;
    logic out_free;
  } sts_t;

endpackage

// File: sv/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: sv/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// Heap datapath: entry store, fill count, sift position, moving entry,
// comparators and the result register.
// ----------------------------------------------------------------------------
module bmhq_dp
  import bmhq_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 32,
  parameter int INDEX_BITS = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  logic      rsp_stall,
  output logic      rsp_valid,
  output rsp_item_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = INDEX_BITS + KEY_BITS;

  logic [CW-1:0]         count;
  logic [AW-1:0]         pos;
  logic [EW-1:0]         cur;
  status_t               res_status;
  logic [INDEX_BITS-1:0] res_idx;
  logic [KEY_BITS-1:0]   res_key;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [EW-1:0] rdata_a;
  logic [EW-1:0] rdata_b;

  logic [EW-1:0]       new_entry;
  logic [KEY_BITS-1:0] cur_key;
  logic [KEY_BITS-1:0] a_key;
  logic [KEY_BITS-1:0] b_key;
  logic [KEY_BITS-1:0] best_key;
  logic [AW-1:0]       parent;
  logic [AW-1:0]       grand;
  logic [AW+1:0]       lc;
  logic [AW+1:0]       rc;
  logic                lv;
  logic                rv;
  logic                l_win;
  logic                r_win;
  logic [AW-1:0]       ch;
  logic [EW-1:0]       ch_entry;
  logic [AW-1:0]       base;
  logic [AW+1:0]       nlc;
  logic [AW+1:0]       nrc;
  logic                out_free;

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    new_entry = {INDEX_BITS'(req.node_index), KEY_BITS'(req.key)};
    cur_key   = cur[KEY_BITS-1:0];
    a_key     = rdata_a[KEY_BITS-1:0];
    b_key     = rdata_b[KEY_BITS-1:0];

    parent = (pos - AW'(1)) >> 1;
    grand  = (parent == '0) ? '0 : ((parent - AW'(1)) >> 1);

    lc       = {1'b0, pos, 1'b1};
    rc       = lc + (AW+2)'(1);
    lv       = lc < (AW+2)'(count);
    rv       = rc < (AW+2)'(count);
    l_win    = lv && (a_key < cur_key);
    best_key = l_win ? a_key : cur_key;
    r_win    = rv && (b_key < best_key);
    ch       = r_win ? rc[AW-1:0] : lc[AW-1:0];
    ch_entry = r_win ? rdata_b : rdata_a;

    base = (cmd.op == DP_DN_STEP) ? ch : '0;
    nlc  = {1'b0, base, 1'b1};
    nrc  = nlc + (AW+2)'(1);

    out_free = !rsp_valid || !rsp_stall;

    we      = 1'b0;
    waddr   = pos;
    wdata   = cur;
    raddr_a = '0;
    raddr_b = '0;
    case (cmd.op)
      DP_PUSH_START: begin
        if (count == '0) begin
          we    = 1'b1;
          waddr = '0;
          wdata = new_entry;
        end else begin
          raddr_a = AW'((count - CW'(1)) >> 1);
        end
      end
      DP_POP_START: begin
        raddr_a = '0;
        raddr_b = AW'(count - CW'(1));
      end
      DP_UP_STEP: begin
        we = 1'b1;
        if (pos != '0 && a_key > cur_key) begin
          wdata   = rdata_a;
          raddr_a = grand;
        end
      end
      DP_POP_LOAD: begin
        raddr_a = (nlc < (AW+2)'(count)) ? nlc[AW-1:0] : '0;
        raddr_b = (nrc < (AW+2)'(count)) ? nrc[AW-1:0] : '0;
      end
      DP_DN_STEP: begin
        we = 1'b1;
        if (l_win || r_win) begin
          wdata   = ch_entry;
          raddr_a = (nlc < (AW+2)'(count)) ? nlc[AW-1:0] : '0;
          raddr_b = (nrc < (AW+2)'(count)) ? nrc[AW-1:0] : '0;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase

    sts.req_pop  = (req.op == OP_POP);
    sts.cnt_zero = (count == '0);
    sts.cnt_full = (count == CW'(CAPACITY));
    sts.pos_root = (pos == '0);
    sts.up_move  = (a_key > cur_key);
    sts.dn_move  = l_win || r_win;
    sts.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (cmd.op)
        DP_PUSH_START: count <= count + CW'(1);
        DP_POP_START:  count <= count - CW'(1);
        default:       count <= count;
      endcase
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_PUSH_START: begin
        cur        <= new_entry;
        pos        <= AW'(count);
        res_status <= ST_OK;
        res_idx    <= '0;
        res_key    <= '0;
      end
      DP_POP_START: begin
        res_status <= ST_OK;
      end
      DP_REFUSE_FULL: begin
        res_status <= ST_FULL;
        res_idx    <= '0;
        res_key    <= '0;
      end
      DP_REFUSE_EMPTY: begin
        res_status <= ST_EMPTY;
        res_idx    <= '0;
        res_key    <= '0;
      end
      DP_UP_STEP: begin
        if (pos != '0 && a_key > cur_key) begin
          pos <= parent;
        end
      end
      DP_POP_LOAD: begin
        res_idx <= rdata_a[EW-1:KEY_BITS];
        res_key <= rdata_a[KEY_BITS-1:0];
        cur     <= rdata_b;
        pos     <= '0;
      end
      DP_DN_STEP: begin
        if (l_win || r_win) begin
          pos <= ch;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
    if (cmd.load_out) begin
      rsp.status         <= res_status;
      rsp.out_node_index <= 20'(res_idx);
      rsp.out_key        <= 32'(res_key);
      rsp.entry_count    <= 11'(count);
      rsp.is_empty       <= (count == '0);
    end
  end

endmodule

// File: sv/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Heap controller: sequences push, pop, sift steps and the result hand-off.
// ----------------------------------------------------------------------------
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic req_stall
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = DP_NONE;
    cmd.load_out = 1'b0;
    req_stall    = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (sts.req_pop) begin
            if (sts.cnt_zero) begin
              cmd.op     = DP_REFUSE_EMPTY;
              state_next = S_RESP;
            end else begin
              cmd.op     = DP_POP_START;
              state_next = S_POP_LOAD;
            end
          end else if (sts.cnt_full) begin
            cmd.op     = DP_REFUSE_FULL;
            state_next = S_RESP;
          end else begin
            cmd.op     = DP_PUSH_START;
            state_next = sts.cnt_zero ? S_RESP : S_UP_CMP;
          end
        end
      end
      S_UP_CMP: begin
        cmd.op = DP_UP_STEP;
        if (sts.pos_root || !sts.up_move) begin
          state_next = S_RESP;
        end
      end
      S_POP_LOAD: begin
        cmd.op     = DP_POP_LOAD;
        state_next = sts.cnt_zero ? S_RESP : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.op = DP_DN_STEP;
        if (!sts.dn_move) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/binary_min_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Binary min-heap priority queue of (node index, key) entries with push and
// pop-minimum operations; every operation returns one status item.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   req     | req_valid/req_stall  | op, node_index, key
//   rsp     | rsp_valid/rsp_stall  | status, out_node_index, out_key,
//           |                      | entry_count, is_empty
//
// One item at a time. Push sifts up and pop sifts down through the heap
// levels, each level step waiting on the registered read of the entry
// store; refused operations walk no levels.
// Reset clears the fill count and control only; the store needs no clearing.
// A stalled result holds in its register; the next item is taken once the
// current result is registered.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit
  import bmhq_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 32,
  parameter int INDEX_BITS = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  bmhq_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// File: sv/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker
  import bmhq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input req_item_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("new item taken while one is in progress");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_empty == (rsp.entry_count == 11'd0))
    else $error("empty flag disagrees with entry count");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY)
      |-> rsp.out_key == 32'd0 && rsp.out_node_index == 20'd0)
    else $error("refused operation returned an entry");

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_chk (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary min-heap queue unit. A queue of push and
// pop items, directed first and then random bursts, a deeper fill and a deep
// drain, is driven under random idling and one long output hold. A shadow
// heap predicts every reply, and each reply is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH  = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int FILL_LEVEL  = 160;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  binary_min_heap_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  req_item_t   op_q[$];
  rsp_item_t   heap_reply_q[$];
  logic [19:0] shadow_idx[HEAP_DEPTH];
  logic [31:0] shadow_key[HEAP_DEPTH];
  int unsigned shadow_fill = 0;
  int unsigned gen_fill = 0;
  int unsigned err_cnt = 0;
  int unsigned reply_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          req_taken = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [19:0] ti;
    logic [31:0] tk;
    ti = shadow_idx[a];
    tk = shadow_key[a];
    shadow_idx[a] = shadow_idx[b];
    shadow_key[a] = shadow_key[b];
    shadow_idx[b] = ti;
    shadow_key[b] = tk;
  endfunction

  function automatic rsp_item_t heap_apply(req_item_t it);
    rsp_item_t   r;
    int unsigned p, up, lc, rc, best;
    r = '0;
    r.status = ST_OK;
    if (it.op == OP_PUSH) begin
      if (shadow_fill >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        p = shadow_fill;
        shadow_idx[p] = it.node_index;
        shadow_key[p] = it.key;
        shadow_fill++;
        while (p > 0) begin
          up = (p - 1) / 2;
          if (shadow_key[up] <= shadow_key[p]) break;
          swap_entries(up, p);
          p = up;
        end
      end
    end else begin
      if (shadow_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_node_index = shadow_idx[0];
        r.out_key = shadow_key[0];
        shadow_fill--;
        shadow_idx[0] = shadow_idx[shadow_fill];
        shadow_key[0] = shadow_key[shadow_fill];
        p = 0;
        forever begin
          lc = 2 * p + 1;
          rc = 2 * p + 2;
          best = p;
          if (lc < shadow_fill && shadow_key[lc] < shadow_key[best]) best = lc;
          if (rc < shadow_fill && shadow_key[rc] < shadow_key[best]) best = rc;
          if (best == p) break;
          swap_entries(p, best);
          p = best;
        end
      end
    end
    r.entry_count = 11'(shadow_fill);
    r.is_empty = (shadow_fill == 0);
    return r;
  endfunction

  function automatic void queue_op(op_t o, logic [19:0] idx, logic [31:0] k);
    req_item_t it;
    it.op = o;
    it.node_index = idx;
    it.key = k;
    op_q.push_back(it);
    if (o == OP_PUSH && gen_fill < HEAP_DEPTH) gen_fill++;
    if (o == OP_POP && gen_fill > 0) gen_fill--;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_push_rand();
    queue_op(OP_PUSH, 20'($urandom), pick_key());
  endfunction

  function automatic bit quiet_phase();
    return reply_cnt >= 250 && reply_cnt < 500;
  endfunction

  // sender: present the next item once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (op_q.size() != 0 && (quiet_phase() || $urandom_range(0, 99) >= 9)) begin
        req <= op_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls and one long hold
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!hold_done && reply_cnt >= 700) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !quiet_phase() && $urandom_range(0, 99) < 9;
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        reply_cnt <= reply_cnt + 1;
        if (heap_reply_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected reply: status %0d node %h key %h count %0d empty %0d",
                     rsp.status, rsp.out_node_index, rsp.out_key, rsp.entry_count,
                     rsp.is_empty);
        end else begin
          want = heap_reply_q.pop_front();
          if (rsp !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("reply mismatch at reply %0d:", reply_cnt);
              $display("  exp status %0d node %h key %h count %0d empty %0d",
                       want.status, want.out_node_index, want.out_key,
                       want.entry_count, want.is_empty);
              $display("  got status %0d node %h key %h count %0d empty %0d",
                       rsp.status, rsp.out_node_index, rsp.out_key,
                       rsp.entry_count, rsp.is_empty);
            end
          end
        end
      end
      if (req_valid && !req_stall) heap_reply_q.push_back(heap_apply(req));
    end
  end

  initial begin
    int unsigned mixed, burst, j;

    // pops on empty, extreme fields, ties on push and pop
    queue_op(OP_POP, 20'h00000, 32'h0000_0000);
    queue_op(OP_PUSH, 20'hFFFFF, 32'hFFFF_FFFF);
    queue_op(OP_PUSH, 20'h00000, 32'h0000_0000);
    queue_op(OP_PUSH, 20'h12345, 32'h8000_0000);
    queue_op(OP_PUSH, 20'h55555, 32'h8000_0000);
    queue_op(OP_PUSH, 20'hAAAAA, 32'h8000_0000);
    queue_op(OP_PUSH, 20'h00001, 32'h0000_0000);
    for (j = 0; j < 7; j++) queue_op(OP_POP, 20'hFFFFF, 32'hFFFF_FFFF);
    queue_op(OP_PUSH, 20'h00010, 32'd5);
    queue_op(OP_PUSH, 20'h00020, 32'd3);
    queue_op(OP_PUSH, 20'h00030, 32'd3);
    queue_op(OP_PUSH, 20'h00040, 32'd7);
    queue_op(OP_PUSH, 20'h00050, 32'd1);
    for (j = 0; j < 5; j++) queue_op(OP_POP, 20'h0, 32'h0);

    // bursts of pushes then pops, with some noise in between
    mixed = 0;
    while (mixed < 580) begin
      if ($urandom_range(0, 3) != 0) begin
        burst = $urandom_range(1, 24);
        for (j = 0; j < burst; j++) queue_push_rand();
        mixed += burst;
        burst = $urandom_range(1, burst + 2);
        for (j = 0; j < burst; j++) queue_op(OP_POP, 20'($urandom), $urandom);
        mixed += burst;
      end else begin
        for (j = 0; j < 8; j++) begin
          if ($urandom_range(0, 1) != 0) queue_push_rand();
          else queue_op(OP_POP, 20'($urandom), $urandom);
        end
        mixed += 8;
      end
    end

    // fill deeper, then drain deep
    while (gen_fill < FILL_LEVEL) queue_push_rand();
    for (j = 0; j < 200; j++) begin
      if ($urandom_range(0, 4) == 0) queue_push_rand();
      else queue_op(OP_POP, 20'($urandom), $urandom);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_q.size() != 0 || req_valid) @(posedge clk);
    while (heap_reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0 && heap_reply_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/bmhq_dp.sv
sv/bmhq_ctrl.sv
sv/binary_min_heap_queue_unit.sv
sv/bmhq_checker.sv
tb/sv/tb_top.sv
